FILE: src/eip_pkg.sv
// Shared types and constants for the Ethernet/VLAN/IPv4/L4 header parser.
// No dependencies; imported by every module of the block.
package eip_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH     = 2;
	localparam int QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] TAG_TYPE  = 16'h8100;
	localparam logic [15:0] IPV4_TYPE = 16'h0800;

	localparam logic [6:0] TYPE_POS    = 7'd12;
	localparam logic [6:0] TAG_LEN     = 7'd4;
	localparam logic [6:0] L3_UNTAGGED = 7'd14;
	localparam logic [6:0] L3_TAGGED   = 7'd18;
	localparam logic [6:0] POS_MAX     = 7'd127;
	localparam logic [6:0] PROTO_OFS   = 7'd9;

	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;
	localparam logic [7:0] PROTO_SCTP = 8'd132;

	localparam logic [6:0] TCP_HDR_LEN  = 7'd20;
	localparam logic [6:0] UDP_HDR_LEN  = 7'd8;
	localparam logic [6:0] SCTP_HDR_LEN = 7'd12;

	typedef enum logic [2:0] {
		ST_RUNT,
		ST_NOT_IPV4,
		ST_OTHER,
		ST_TRUNC,
		ST_TCP,
		ST_UDP,
		ST_SCTP
	} eip_status_t;

	// one classified frame, front to back
	typedef struct packed {
		eip_status_t status;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] payload_len;
		logic [6:0]  payload_offset;
	} eip_rec_t;

	typedef struct packed {
		logic empty;
		logic full;
	} eip_qstat_t;

endpackage

FILE: src/eip_front.sv
// Byte-level front end: tracks position in the frame, captures header fields
// and classifies the frame on its last byte. Depends on eip_pkg.
module eip_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	input  eip_pkg::eip_qstat_t qstat,
	output logic                push,
	output eip_pkg::eip_rec_t   rec
);
	import eip_pkg::*;

	logic [6:0]  pos_q;
	logic        vlan_q;
	logic [15:0] etype_q;
	logic [5:0]  ihl_q;
	logic [15:0] tot_q;
	logic [7:0]  proto_q;
	logic [31:0] ports_q;

	logic [15:0] etype_n;
	logic        vlan_n;
	logic [5:0]  ihl_n;
	logic [15:0] tot_n;
	logic [7:0]  proto_n;
	logic [31:0] ports_n;
	logic [6:0]  l3;
	logic [6:0]  l3_rel;
	logic [6:0]  l4_rel;
	logic [6:0]  l4_start;
	logic [6:0]  l4_len;
	logic        accept;

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && in_last;

	always_comb begin
		etype_n = etype_q;
		vlan_n  = vlan_q;
		ihl_n   = ihl_q;
		tot_n   = tot_q;
		proto_n = proto_q;
		ports_n = ports_q;

		if (pos_q == TYPE_POS) begin
			etype_n = {in_byte, 8'h00};
		end else if (pos_q == TYPE_POS + 7'd1) begin
			etype_n = {etype_q[15:8], in_byte};
			vlan_n  = ({etype_q[15:8], in_byte} == TAG_TYPE);
		end
		l3 = vlan_n ? L3_TAGGED : L3_UNTAGGED;
		// inner ethertype after the tag
		if (vlan_n && pos_q == TYPE_POS + TAG_LEN) begin
			etype_n = {in_byte, 8'h00};
		end else if (vlan_n && pos_q == TYPE_POS + TAG_LEN + 7'd1) begin
			etype_n = {etype_n[15:8], in_byte};
		end

		if (pos_q == l3) begin
			ihl_n = {in_byte[3:0], 2'b00};
		end else if (pos_q == l3 + 7'd2) begin
			tot_n = {in_byte, 8'h00};
		end else if (pos_q == l3 + 7'd3) begin
			tot_n = {tot_q[15:8], in_byte};
		end else if (pos_q == l3 + PROTO_OFS) begin
			proto_n = in_byte;
		end

		// port bytes sit at l3 + ihl .. +3, even when ihl is below 20
		l3_rel   = pos_q - l3;
		l4_rel   = l3_rel - {1'b0, ihl_n};
		l4_start = l3 + {1'b0, ihl_n};
		if (pos_q >= l3 && l3_rel >= {1'b0, ihl_n} && l4_rel < 7'd4) begin
			ports_n = {ports_q[23:0], in_byte};
		end

		rec    = '0;
		l4_len = '0;
		if (pos_q < TYPE_POS + 7'd1) begin
			rec.status = ST_RUNT;
		end else if (pos_q < l3 - 7'd1) begin
			rec.status = ST_TRUNC;
		end else if (etype_n != IPV4_TYPE) begin
			rec.status = ST_NOT_IPV4;
		end else if (pos_q < l3 + PROTO_OFS) begin
			rec.status = ST_TRUNC;
		end else if (proto_n != PROTO_TCP && proto_n != PROTO_UDP && proto_n != PROTO_SCTP) begin
			rec.status = ST_OTHER;
		end else if (pos_q < l4_start + 7'd3) begin
			rec.status = ST_TRUNC;
		end else if (proto_n == PROTO_TCP) begin
			rec.status = ST_TCP;
			l4_len     = TCP_HDR_LEN;
		end else if (proto_n == PROTO_UDP) begin
			rec.status = ST_UDP;
			l4_len     = UDP_HDR_LEN;
		end else begin
			rec.status = ST_SCTP;
			l4_len     = SCTP_HDR_LEN;
		end

		if (rec.status == ST_TCP || rec.status == ST_UDP || rec.status == ST_SCTP) begin
			rec.src_port       = ports_n[31:16];
			rec.dst_port       = ports_n[15:0];
			rec.payload_len    = tot_n - {10'd0, ihl_n};
			rec.payload_offset = l4_start + l4_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			vlan_q  <= 1'b0;
			etype_q <= '0;
			ihl_q   <= '0;
			tot_q   <= '0;
			proto_q <= '0;
			ports_q <= '0;
		end else if (accept) begin
			if (in_last) begin
				pos_q   <= '0;
				vlan_q  <= 1'b0;
				etype_q <= '0;
				ihl_q   <= '0;
				tot_q   <= '0;
				proto_q <= '0;
				ports_q <= '0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 7'd1;
				end
				vlan_q  <= vlan_n;
				etype_q <= etype_n;
				ihl_q   <= ihl_n;
				tot_q   <= tot_n;
				proto_q <= proto_n;
				ports_q <= ports_n;
			end
		end
	end

endmodule

FILE: src/eip_queue.sv
// Short queue of classified frame records between front and back end.
// Depends on eip_pkg.
module eip_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  eip_pkg::eip_rec_t   wr_rec,
	input  logic                pop,
	output eip_pkg::eip_rec_t   rd_rec,
	output eip_pkg::eip_qstat_t qstat
);
	import eip_pkg::*;

	eip_rec_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign qstat.empty = (cnt_q == '0);
	assign qstat.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign rd_rec      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/eip_back.sv
// Back end: frame and protocol counters plus the registered result stage.
// Depends on eip_pkg.
module eip_back #(
	parameter int COUNT_WIDTH = eip_pkg::COUNT_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  eip_pkg::eip_qstat_t qstat,
	input  eip_pkg::eip_rec_t   rec,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [151:0]        out_data,
	output logic [2:0]          out_user
);
	import eip_pkg::*;

	logic [COUNT_WIDTH-1:0] frame_cnt_q;
	logic [COUNT_WIDTH-1:0] tcp_cnt_q;
	logic [COUNT_WIDTH-1:0] udp_cnt_q;
	logic [COUNT_WIDTH-1:0] frame_cnt_n;
	logic [COUNT_WIDTH-1:0] tcp_cnt_n;
	logic [COUNT_WIDTH-1:0] udp_cnt_n;
	logic                   valid_q;
	logic [151:0]           data_q;
	logic [2:0]             user_q;

	assign pop       = !qstat.empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_user  = user_q;

	always_comb begin
		frame_cnt_n = frame_cnt_q + 1'b1;
		tcp_cnt_n   = (rec.status == ST_TCP) ? tcp_cnt_q + 1'b1 : tcp_cnt_q;
		udp_cnt_n   = (rec.status == ST_UDP) ? udp_cnt_q + 1'b1 : udp_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			frame_cnt_q <= '0;
			tcp_cnt_q   <= '0;
			udp_cnt_q   <= '0;
		end else begin
			if (pop) begin
				valid_q     <= 1'b1;
				frame_cnt_q <= frame_cnt_n;
				tcp_cnt_q   <= tcp_cnt_n;
				udp_cnt_q   <= udp_cnt_n;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			user_q <= rec.status;
			data_q <= {1'b0, 32'(udp_cnt_n), 32'(tcp_cnt_n), 32'(frame_cnt_n),
				rec.payload_offset, rec.payload_len, rec.dst_port, rec.src_port};
		end
	end

endmodule

FILE: src/eth_ipv4_l4_header_parser.sv
// Ethernet/VLAN/IPv4 header parser with TCP/UDP/SCTP port extraction.
// Top level; depends on eip_pkg, eip_front, eip_queue and eip_back.
//
// Frame bytes enter one per transfer on s_axis, tlast on the final byte, and
// the block takes one byte every cycle while the record queue has room. Each
// frame yields one result transfer on m_axis; its record passes through the
// record queue and then the output register. The front end only stalls when
// the two-entry record queue is full, which needs the output side to hold off
// for a run of very short frames. Results carry the frame status in tuser,
// and ports, payload length, payload offset and the running frame, TCP and
// UDP counters in tdata; counters wrap at COUNT_WIDTH bits and show their low
// 32 bits.
module eth_ipv4_l4_header_parser #(
	parameter int COUNT_WIDTH = eip_pkg::COUNT_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // [7:0] byte_value
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [15:0] src_port, [31:16] dst_port, [47:32] payload_len,
	// [54:48] payload_offset, [86:55] frames_seen, [118:87] tcp_seen,
	// [150:119] udp_seen, [151] zero
	output logic [151:0] m_axis_tdata,
	output logic [2:0]   m_axis_tuser   // [2:0] status
);
	import eip_pkg::*;

	eip_qstat_t qstat;
	eip_rec_t   wr_rec;
	eip_rec_t   rd_rec;
	logic       push;
	logic       pop;

	eip_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.qstat    (qstat),
		.push     (push),
		.rec      (wr_rec)
	);

	eip_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (wr_rec),
		.pop    (pop),
		.rd_rec (rd_rec),
		.qstat  (qstat)
	);

	eip_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.rec       (rd_rec),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

	// the queue never takes a record it has no room for
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full && !pop))
		else $error("record queue overflow");

	// non-L4 results carry zero ports, length and offset
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == ST_RUNT || m_axis_tuser == ST_NOT_IPV4 ||
			m_axis_tuser == ST_OTHER || m_axis_tuser == ST_TRUNC))
		|-> (m_axis_tdata[54:0] == '0))
		else $error("non-L4 result with non-zero fields");

	// a taken result with nothing queued leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && qstat.empty) |=> !m_axis_tvalid)
		else $error("stale result after transfer");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for eth_ipv4_l4_header_parser: frames go in byte by byte on s_axis and
// every frame summary on m_axis is checked against an in-bench parser of the same headers.
// Depends on eip_pkg and the block's RTL only.
module testbench;
	import eip_pkg::*;

	localparam int RUN_LIMIT  = 400_000;
	localparam int MIN_BYTES  = 1600;
	localparam int MIN_FRAMES = 48;
	localparam int TAIL_WAIT  = 16;

	typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
	typedef enum logic [2:0] {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_TRICKLE, SINK_SHUT} sink_mode_t;

	// one frame to send: header fields plus the status it must give, where that is plain
	typedef struct packed {
		logic [7:0]  n_bytes;
		logic        has_tag;
		logic [15:0] etype;
		logic [3:0]  ihl;
		logic [15:0] tot_len;
		logic [7:0]  proto;
		logic [15:0] sport;
		logic [15:0] dport;
		fill_t       fill;
		logic        pinned;
		eip_status_t want;
	} frame_desc_t;

	typedef struct packed {
		eip_status_t status;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] payload_len;
		logic [6:0]  payload_offset;
		logic [31:0] frames_seen;
		logic [31:0] tcp_seen;
		logic [31:0] udp_seen;
	} frame_summary_t;

	typedef struct packed {
		logic        on;
		eip_status_t st;
	} status_pin_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = 8'h00;
	logic         s_axis_tlast = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [151:0] m_axis_tdata;
	logic [2:0]   m_axis_tuser;

	eth_ipv4_l4_header_parser DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// parser state mirrored in the bench
	int          hdr_pos = 0;
	logic        hdr_tagged = 1'b0;
	logic [15:0] hdr_etype = '0;
	logic [5:0]  hdr_ihl4 = '0;
	logic [15:0] hdr_tot_len = '0;
	logic [7:0]  hdr_proto = '0;
	logic [31:0] hdr_ports = '0;
	logic [31:0] n_frames = '0;
	logic [31:0] n_tcp = '0;
	logic [31:0] n_udp = '0;

	frame_summary_t frame_summary_q[$];
	status_pin_t    status_pin_q[$];
	int             frames_sent = 0;
	int             summaries_seen = 0;
	int             bytes_sent = 0;
	int             mismatch_count = 0;
	int             burst_left = 0;
	int             cycle_count = 0;
	sink_mode_t     sink_mode = SINK_OPEN;
	int             sink_left = 0;

	task automatic classify_byte(input logic [7:0] b, input logic is_last, output bit done,
			output frame_summary_t sum);
		int pos, l3, hl, tpos, l4_len;
		eip_status_t st;
		pos = hdr_pos;
		tpos = int'(TYPE_POS);
		done = 1'b0;
		sum = '0;
		l4_len = 0;
		if (pos == tpos) begin
			hdr_etype = {b, 8'h00};
		end else if (pos == tpos + 1) begin
			hdr_etype[7:0] = b;
			hdr_tagged = (hdr_etype == TAG_TYPE);
		end
		l3 = hdr_tagged ? int'(L3_TAGGED) : int'(L3_UNTAGGED);
		// with a tag the ethertype is read again after it
		if (hdr_tagged && pos == tpos + int'(TAG_LEN))
			hdr_etype = {b, 8'h00};
		else if (hdr_tagged && pos == tpos + int'(TAG_LEN) + 1)
			hdr_etype[7:0] = b;

		if (pos == l3)
			hdr_ihl4 = {b[3:0], 2'b00};
		else if (pos == l3 + 2)
			hdr_tot_len = {b, 8'h00};
		else if (pos == l3 + 3)
			hdr_tot_len[7:0] = b;
		else if (pos == l3 + int'(PROTO_OFS))
			hdr_proto = b;

		hl = int'(hdr_ihl4);
		if (pos >= l3 + hl && pos < l3 + hl + 4)
			hdr_ports = {hdr_ports[23:0], b};

		if (!is_last) begin
			if (hdr_pos < int'(POS_MAX))
				hdr_pos++;
			return;
		end

		if (pos < tpos + 1)
			st = ST_RUNT;
		else if (pos < l3 - 1)
			st = ST_TRUNC;
		else if (hdr_etype != IPV4_TYPE)
			st = ST_NOT_IPV4;
		else if (pos < l3 + int'(PROTO_OFS))
			st = ST_TRUNC;
		else if (hdr_proto != PROTO_TCP && hdr_proto != PROTO_UDP && hdr_proto != PROTO_SCTP)
			st = ST_OTHER;
		else if (pos < l3 + hl + 3)
			st = ST_TRUNC;
		else if (hdr_proto == PROTO_TCP) begin
			st = ST_TCP;
			l4_len = int'(TCP_HDR_LEN);
		end else if (hdr_proto == PROTO_UDP) begin
			st = ST_UDP;
			l4_len = int'(UDP_HDR_LEN);
		end else begin
			st = ST_SCTP;
			l4_len = int'(SCTP_HDR_LEN);
		end

		n_frames++;
		if (st == ST_TCP)
			n_tcp++;
		if (st == ST_UDP)
			n_udp++;

		sum.status = st;
		if (st inside {ST_TCP, ST_UDP, ST_SCTP}) begin
			sum.src_port       = hdr_ports[31:16];
			sum.dst_port       = hdr_ports[15:0];
			sum.payload_len    = hdr_tot_len - 16'(hl);
			sum.payload_offset = 7'(l3 + hl + l4_len);
		end
		sum.frames_seen = n_frames;
		sum.tcp_seen    = n_tcp;
		sum.udp_seen    = n_udp;
		done = 1'b1;

		hdr_pos = 0;
		hdr_tagged = 1'b0;
		hdr_etype = '0;
		hdr_ihl4 = '0;
		hdr_tot_len = '0;
		hdr_proto = '0;
		hdr_ports = '0;
	endtask

	function automatic void check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// result check first, then prediction: a frame's summary cannot leave in the cycle its
	// last byte goes in
	always @(posedge clk) begin : frame_monitor
		frame_summary_t want, got;
		status_pin_t pin;
		bit done;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.status         = eip_status_t'(m_axis_tuser);
				got.src_port       = m_axis_tdata[15:0];
				got.dst_port       = m_axis_tdata[31:16];
				got.payload_len    = m_axis_tdata[47:32];
				got.payload_offset = m_axis_tdata[54:48];
				got.frames_seen    = m_axis_tdata[86:55];
				got.tcp_seen       = m_axis_tdata[118:87];
				got.udp_seen       = m_axis_tdata[150:119];
				if (frame_summary_q.size() == 0) begin
					$error("frame summary with no frame pending");
					mismatch_count++;
				end else begin
					want = frame_summary_q.pop_front();
					check_field("status", want.status, got.status);
					check_field("src_port", want.src_port, got.src_port);
					check_field("dst_port", want.dst_port, got.dst_port);
					check_field("payload_len", want.payload_len, got.payload_len);
					check_field("payload_offset", want.payload_offset, got.payload_offset);
					check_field("frames_seen", want.frames_seen, got.frames_seen);
					check_field("tcp_seen", want.tcp_seen, got.tcp_seen);
					check_field("udp_seen", want.udp_seen, got.udp_seen);
					summaries_seen++;
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				classify_byte(s_axis_tdata, s_axis_tlast, done, want);
				if (done) begin
					pin = status_pin_q.pop_front();
					if (pin.on)
						want.status = pin.st;
					frame_summary_q.push_back(want);
				end
			end
		end
	end

	// output side stalls in spells of differing character
	always @(posedge clk) begin : sink_pattern
		if (sink_left == 0) begin
			sink_mode = sink_mode_t'($urandom_range(0, 4));
			sink_left = $urandom_range(8, 120);
		end
		sink_left--;
		case (sink_mode)
			SINK_OPEN:    m_axis_tready <= 1'b1;
			SINK_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
			SINK_MOSTLY:  m_axis_tready <= ($urandom_range(0, 7) != 0);
			SINK_TRICKLE: m_axis_tready <= (sink_left % 16 == 0);
			default:      m_axis_tready <= 1'b0;
		endcase
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count == RUN_LIMIT) begin
			$display("eth_ipv4_l4_header_parser regression: fail");
			$finish;
		end
	end

	// one byte transfer; the sender runs in bursts with idle gaps between them
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 24);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= is_last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_frame(input frame_desc_t d);
		logic [7:0] img [256];
		int l3, po;
		for (int i = 0; i < 256; i++) begin
			case (d.fill)
				FILL_ZERO: img[i] = 8'h00;
				FILL_ONES: img[i] = 8'hFF;
				default:   img[i] = 8'($urandom_range(0, 255));
			endcase
		end
		l3 = d.has_tag ? int'(L3_TAGGED) : int'(L3_UNTAGGED);
		po = l3 + 4 * int'(d.ihl);
		// ports first, so a small IHL lets header fields overwrite them
		{img[po], img[po + 1]}     = d.sport;
		{img[po + 2], img[po + 3]} = d.dport;
		if (d.has_tag)
			{img[12], img[13]} = TAG_TYPE;
		{img[l3 - 2], img[l3 - 1]} = d.etype;
		img[l3] = {4'h4, d.ihl};
		{img[l3 + 2], img[l3 + 3]} = d.tot_len;
		img[l3 + int'(PROTO_OFS)] = d.proto;
		status_pin_q.push_back('{d.pinned, d.want});
		for (int i = 0; i < int'(d.n_bytes); i++)
			send_byte(img[i], i == int'(d.n_bytes) - 1);
		bytes_sent += int'(d.n_bytes);
		frames_sent++;
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (summaries_seen != frames_sent);
	endtask

	function automatic frame_desc_t random_frame();
		frame_desc_t d;
		int r, l3, full;
		d = '0;
		d.has_tag = ($urandom_range(0, 3) == 0);
		r = $urandom_range(0, 19);
		if (r < 16)
			d.etype = IPV4_TYPE;
		else if (r == 16)
			d.etype = 16'h86DD;
		else if (r == 17)
			d.etype = TAG_TYPE;
		else
			d.etype = 16'($urandom_range(0, 65535));
		r = $urandom_range(0, 7);
		if (r < 4)
			d.ihl = 4'd5;
		else if (r == 7)
			d.ihl = 4'($urandom_range(0, 4));
		else
			d.ihl = 4'($urandom_range(5, 15));
		r = $urandom_range(0, 9);
		if (r < 3)
			d.proto = PROTO_TCP;
		else if (r < 6)
			d.proto = PROTO_UDP;
		else if (r < 8)
			d.proto = PROTO_SCTP;
		else
			d.proto = 8'($urandom_range(0, 255));
		d.tot_len = 16'($urandom_range(0, 65535));
		d.sport   = 16'($urandom_range(0, 65535));
		d.dport   = 16'($urandom_range(0, 65535));
		r = $urandom_range(0, 9);
		d.fill = (r == 8) ? FILL_ZERO : (r == 9) ? FILL_ONES : FILL_RANDOM;
		l3 = d.has_tag ? int'(L3_TAGGED) : int'(L3_UNTAGGED);
		full = l3 + 4 * int'(d.ihl) + 4;
		if (full < l3 + int'(PROTO_OFS) + 1)
			full = l3 + int'(PROTO_OFS) + 1;
		r = $urandom_range(0, 29);
		if (r < 4)
			d.n_bytes = 8'($urandom_range(1, full - 1));
		else if (r == 4)
			d.n_bytes = 8'($urandom_range(full, 160));
		else
			d.n_bytes = 8'(full + $urandom_range(0, 6));
		return d;
	endfunction

	frame_desc_t directed_frames [20];

	initial begin : stimulus
		directed_frames = '{
			// lone byte straight after reset
			'{8'd1, 1'b0, IPV4_TYPE, 4'd5, 16'd40, PROTO_TCP, 16'h0000, 16'h0000,
				FILL_ZERO, 1'b1, ST_RUNT},
			'{8'd13, 1'b0, IPV4_TYPE, 4'd5, 16'd40, PROTO_TCP, 16'hFFFF, 16'hFFFF,
				FILL_ONES, 1'b1, ST_RUNT},
			'{8'd14, 1'b0, IPV4_TYPE, 4'd5, 16'd40, PROTO_TCP, 16'h0101, 16'h0202,
				FILL_RANDOM, 1'b1, ST_TRUNC},
			// tag but no inner ethertype
			'{8'd16, 1'b1, IPV4_TYPE, 4'd5, 16'd40, PROTO_TCP, 16'h0101, 16'h0202,
				FILL_RANDOM, 1'b1, ST_TRUNC},
			'{8'd18, 1'b1, IPV4_TYPE, 4'd5, 16'd40, PROTO_UDP, 16'h0101, 16'h0202,
				FILL_RANDOM, 1'b1, ST_TRUNC},
			'{8'd60, 1'b0, 16'h86DD, 4'd5, 16'd40, PROTO_TCP, 16'h0101, 16'h0202,
				FILL_RANDOM, 1'b1, ST_NOT_IPV4},
			// second tag
			'{8'd60, 1'b1, TAG_TYPE, 4'd5, 16'd40, PROTO_TCP, 16'h0101, 16'h0202,
				FILL_RANDOM, 1'b1, ST_NOT_IPV4},
			'{8'd38, 1'b0, 16'hFFFF, 4'd5, 16'd40, PROTO_TCP, 16'h0101, 16'h0202,
				FILL_ONES, 1'b1, ST_NOT_IPV4},
			// ends before the protocol byte
			'{8'd22, 1'b0, IPV4_TYPE, 4'd5, 16'd40, PROTO_TCP, 16'h0101, 16'h0202,
				FILL_RANDOM, 1'b1, ST_TRUNC},
			'{8'd38, 1'b0, IPV4_TYPE, 4'd5, 16'd40, 8'h00, 16'h0101, 16'h0202,
				FILL_ZERO, 1'b1, ST_OTHER},
			'{8'd38, 1'b0, IPV4_TYPE, 4'd5, 16'd40, 8'hFF, 16'h0101, 16'h0202,
				FILL_ONES, 1'b1, ST_OTHER},
			// one byte short of the ports
			'{8'd37, 1'b0, IPV4_TYPE, 4'd5, 16'd40, PROTO_TCP, 16'h0101, 16'h0202,
				FILL_RANDOM, 1'b1, ST_TRUNC},
			// total length below header length: payload length wraps
			'{8'd38, 1'b0, IPV4_TYPE, 4'd5, 16'h0000, PROTO_TCP, 16'h0000, 16'h0000,
				FILL_ZERO, 1'b1, ST_TCP},
			'{8'd38, 1'b0, IPV4_TYPE, 4'd5, 16'hFFFF, PROTO_UDP, 16'hFFFF, 16'hFFFF,
				FILL_ONES, 1'b1, ST_UDP},
			'{8'd42, 1'b1, IPV4_TYPE, 4'd5, 16'd100, PROTO_SCTP, 16'h1234, 16'h5678,
				FILL_RANDOM, 1'b1, ST_SCTP},
			'{8'd78, 1'b0, IPV4_TYPE, 4'd15, 16'd1500, PROTO_TCP, 16'h8000, 16'h0001,
				FILL_RANDOM, 1'b1, ST_TCP},
			// largest payload offset
			'{8'd82, 1'b1, IPV4_TYPE, 4'd15, 16'd1500, PROTO_TCP, 16'h0050, 16'hC000,
				FILL_RANDOM, 1'b1, ST_TCP},
			// IHL of zero: ports come from inside the IP header
			'{8'd24, 1'b0, IPV4_TYPE, 4'd0, 16'd20, PROTO_TCP, 16'hAAAA, 16'h5555,
				FILL_RANDOM, 1'b0, ST_TCP},
			// port bytes overlap the protocol byte
			'{8'd40, 1'b0, IPV4_TYPE, 4'd2, 16'd60, PROTO_UDP, 16'h5555, 16'hAAAA,
				FILL_RANDOM, 1'b0, ST_UDP},
			// long enough for the byte position to saturate
			'{8'd200, 1'b1, IPV4_TYPE, 4'd5, 16'd180, PROTO_TCP, 16'h0400, 16'h0016,
				FILL_RANDOM, 1'b1, ST_TCP}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_frames[i])
			send_frame(directed_frames[i]);
		// hold off until the pipeline is empty before the random traffic
		drain_results();

		while (bytes_sent < MIN_BYTES || frames_sent < MIN_FRAMES) begin
			send_frame(random_frame());
			if ($urandom_range(0, 24) == 0)
				drain_results();
		end

		drain_results();
		repeat (TAIL_WAIT) @(posedge clk);
		if (frame_summary_q.size() != 0) begin
			$error("%0d frame summaries never arrived", frame_summary_q.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("eth_ipv4_l4_header_parser regression: pass");
		else
			$display("eth_ipv4_l4_header_parser regression: fail");
		$finish;
	end

endmodule
